[hw/rtl/wcrb_pkg.sv]
`timescale 1ns / 1ps

package wcrb_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COUNT_W     = 48;
  localparam int LEN_W       = 16;
  localparam int KIND_W      = 2;
  localparam int CAP_W       = 7;
  localparam int NCH_W       = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int IO_CHANNELS = 2;
  localparam int CAP_MAX     = 127;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RING_CAPACITY   = 2'd1;

  localparam logic [NCH_W-1:0] ACTIVE_RESET   = 2'd2;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic STATUS_FRAME = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] chan0_in;
    logic signed [SAMPLE_W-1:0] chan1_in;
    logic [LEN_W-1:0]           window_length;
    logic [COUNT_W-1:0]         window_end;
  } in_item_t;

  typedef struct packed {
    logic                       status;
    logic signed [SAMPLE_W-1:0] chan0_out;
    logic signed [SAMPLE_W-1:0] chan1_out;
    logic [COUNT_W-1:0]         frame_index;
    logic [COUNT_W-1:0]         total_written;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] chan0;
    logic [SAMPLE_W-1:0] chan1;
    logic [CAP_W-1:0]    len;
    logic [COUNT_W-1:0]  window_end;
  } cmd_t;

  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic [NCH_W-1:0] nch;
    logic             flush;
  } ctl_t;

endpackage

[hw/rtl/wcrb_front.sv]
`timescale 1ns / 1ps

module wcrb_front #(
  parameter int DEPTH    = 64,
  parameter int CHANNELS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wcrb_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [wcrb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wcrb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output wcrb_pkg::cmd_t                      cmd,
  output wcrb_pkg::ctl_t                      ctl
);

  localparam int LANES     = (CHANNELS < wcrb_pkg::IO_CHANNELS) ? CHANNELS : wcrb_pkg::IO_CHANNELS;
  localparam int USE_DEPTH = (DEPTH < wcrb_pkg::CAP_MAX) ? DEPTH : wcrb_pkg::CAP_MAX;

  logic [wcrb_pkg::NCH_W-1:0] active_r;
  logic [wcrb_pkg::CAP_W-1:0] capacity_r;
  logic [wcrb_pkg::CAP_W-1:0] cap;
  logic [wcrb_pkg::NCH_W-1:0] nch;
  logic                       known_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= wcrb_pkg::ACTIVE_RESET;
      capacity_r <= wcrb_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == wcrb_pkg::CFG_ACTIVE_CHANNELS) begin
        active_r <= cfg_data[wcrb_pkg::NCH_W-1:0];
      end
      if (cfg_index == wcrb_pkg::CFG_RING_CAPACITY) begin
        capacity_r <= cfg_data[wcrb_pkg::CAP_W-1:0];
      end
    end
  end

  always_comb begin
    if (capacity_r == '0) begin
      cap = wcrb_pkg::CAP_W'(1);
    end else if (capacity_r > wcrb_pkg::CAP_W'(USE_DEPTH)) begin
      cap = wcrb_pkg::CAP_W'(USE_DEPTH);
    end else begin
      cap = capacity_r;
    end
    if (active_r == '0) begin
      nch = wcrb_pkg::NCH_W'(1);
    end else if (active_r > wcrb_pkg::NCH_W'(LANES)) begin
      nch = wcrb_pkg::NCH_W'(LANES);
    end else begin
      nch = active_r;
    end
  end

  assign ctl.cap   = cap;
  assign ctl.nch   = nch;
  assign ctl.flush = cfg_we && ((cfg_index == wcrb_pkg::CFG_ACTIVE_CHANNELS) ||
                                (cfg_index == wcrb_pkg::CFG_RING_CAPACITY));

  // drop unknown kinds at the door
  assign known_kind = (in_data.kind == wcrb_pkg::KIND_PUSH) ||
                      (in_data.kind == wcrb_pkg::KIND_READ) ||
                      (in_data.kind == wcrb_pkg::KIND_CLEAR);
  assign in_ready   = cmd_ready;
  assign cmd_valid  = in_valid && known_kind;

  always_comb begin
    cmd.kind       = in_data.kind;
    cmd.chan0      = in_data.chan0_in;
    cmd.chan1      = in_data.chan1_in;
    cmd.window_end = in_data.window_end;
    if (in_data.window_length == '0) begin
      cmd.len = wcrb_pkg::CAP_W'(1);
    end else if (in_data.window_length > wcrb_pkg::LEN_W'(cap)) begin
      cmd.len = cap;
    end else begin
      cmd.len = in_data.window_length[wcrb_pkg::CAP_W-1:0];
    end
  end

endmodule

[hw/rtl/wcrb_cmd_queue.sv]
`timescale 1ns / 1ps

module wcrb_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  wcrb_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wcrb_pkg::cmd_t pop_cmd
);

  wcrb_pkg::cmd_t                  slot_r [wcrb_pkg::QUEUE_DEPTH];
  logic [wcrb_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [wcrb_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [wcrb_pkg::QPTR_W:0]       count_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count_r != (wcrb_pkg::QPTR_W+1)'(wcrb_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/wcrb_back.sv]
`timescale 1ns / 1ps

module wcrb_back #(
  parameter int DEPTH    = 64,
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wcrb_pkg::ctl_t      ctl,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  wcrb_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output wcrb_pkg::out_item_t out_data
);

  localparam int LANES     = (CHANNELS < wcrb_pkg::IO_CHANNELS) ? CHANNELS : wcrb_pkg::IO_CHANNELS;
  localparam int USE_DEPTH = (DEPTH < wcrb_pkg::CAP_MAX) ? DEPTH : wcrb_pkg::CAP_MAX;
  localparam int AW        = (USE_DEPTH > 1) ? $clog2(USE_DEPTH) : 1;
  localparam int SW        = wcrb_pkg::SAMPLE_W;
  localparam int CW        = wcrb_pkg::COUNT_W;
  localparam int KW        = wcrb_pkg::CAP_W;
  localparam int WORD_W    = LANES * SW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EARLY = 3'd1;
  localparam logic [2:0] ST_END   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_FAIL  = 3'd6;

  logic [WORD_W-1:0]   mem [USE_DEPTH];
  logic [WORD_W-1:0]   wr_word;
  logic [WORD_W-1:0]   rd_data_r;
  logic [SW-1:0]       in_lane [wcrb_pkg::IO_CHANNELS];
  logic [SW-1:0]       rd_lane [wcrb_pkg::IO_CHANNELS];

  logic [2:0]          state_r;
  logic [AW-1:0]       wpos_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       end_r;
  logic [CW-1:0]       earliest_r;
  logic [CW-1:0]       idx_r;
  logic [KW-1:0]       len_r;
  logic [KW-1:0]       left_r;
  logic [AW-1:0]       addr_r;

  logic                pend_r;
  logic                pend_mem_r;
  wcrb_pkg::out_item_t pend_meta_r;

  wcrb_pkg::out_item_t ofifo_r [2];
  logic                owr_r;
  logic                ord_r;
  logic [1:0]          occ_r;

  logic                pop;
  logic                credit;
  logic                issue;
  logic                take;
  wcrb_pkg::out_item_t push_item;
  logic [AW-1:0]       wpos_inc;
  logic [AW-1:0]       addr_inc;
  logic [CW:0]         start_diff;
  logic [KW:0]         addr_sum;
  logic [KW:0]         age;
  logic [KW:0]         addr_fold;

  assign in_lane[0] = cmd.chan0;
  assign in_lane[1] = cmd.chan1;

  for (genvar g = 0; g < wcrb_pkg::IO_CHANNELS; g++) begin : g_lane
    if (g < LANES) begin : g_live
      assign wr_word[g*SW +: SW] = in_lane[g];
      assign rd_lane[g] = (wcrb_pkg::NCH_W'(g) < ctl.nch) ? rd_data_r[g*SW +: SW] : '0;
    end else begin : g_absent
      assign rd_lane[g] = '0;
    end
  end

  assign cmd_ready = (state_r == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign pop       = out_valid && out_ready;
  assign credit    = (3'(occ_r) + 3'(pend_r) - 3'(pop)) < 3'd2;
  assign issue     = ((state_r == ST_EMIT) || (state_r == ST_FAIL)) && credit;

  assign wpos_inc  = (KW'(wpos_r) + 1'b1 == ctl.cap) ? '0 : wpos_r + 1'b1;
  assign addr_inc  = (KW'(addr_r) + 1'b1 == ctl.cap) ? '0 : addr_r + 1'b1;

  assign start_diff = {1'b0, end_r} - {{(CW-KW+1){1'b0}}, len_r};
  assign age        = {1'b0, KW'(count_r[KW-1:0] - idx_r[KW-1:0])};
  assign addr_sum   = (KW+1)'(KW'(wpos_r)) + (KW+1)'(ctl.cap) - age;
  assign addr_fold  = (addr_sum >= (KW+1)'(ctl.cap)) ? addr_sum - (KW+1)'(ctl.cap) : addr_sum;

  always_ff @(posedge clk) begin
    if (take && (cmd.kind == wcrb_pkg::KIND_PUSH)) begin
      mem[wpos_r] <= wr_word;
    end
    if (issue && (state_r == ST_EMIT)) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wpos_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= issue;
      if (ctl.flush) begin
        wpos_r  <= '0;
        count_r <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            case (cmd.kind)
              wcrb_pkg::KIND_PUSH: begin
                wpos_r <= wpos_inc;
                if (count_r != wcrb_pkg::COUNT_MAX) begin
                  count_r <= count_r + 1'b1;
                end
              end
              wcrb_pkg::KIND_CLEAR: begin
                wpos_r  <= '0;
                count_r <= '0;
              end
              default: begin
                state_r <= ST_EARLY;
              end
            endcase
          end
        end
        ST_EARLY: state_r <= ST_END;
        ST_END:   state_r <= ST_START;
        ST_START: begin
          state_r <= (end_r <= earliest_r) ? ST_FAIL : ST_ADDR;
        end
        ST_ADDR:  state_r <= ST_EMIT;
        ST_EMIT: begin
          if (issue && (left_r == KW'(1))) begin
            state_r <= ST_IDLE;
          end
        end
        ST_FAIL: begin
          if (issue) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        end_r <= cmd.window_end;
        len_r <= cmd.len;
      end
      ST_EARLY: begin
        earliest_r <= (count_r > CW'(ctl.cap)) ? count_r - CW'(ctl.cap) : '0;
      end
      ST_END: begin
        if (end_r < earliest_r) begin
          end_r <= earliest_r;
        end else if (end_r > count_r) begin
          end_r <= count_r;
        end
      end
      ST_START: begin
        if (start_diff[CW] || (start_diff[CW-1:0] < earliest_r)) begin
          idx_r <= earliest_r;
        end else begin
          idx_r <= start_diff[CW-1:0];
        end
      end
      ST_ADDR: begin
        left_r <= KW'(end_r[KW-1:0] - idx_r[KW-1:0]);
        addr_r <= AW'(addr_fold);
      end
      ST_EMIT: begin
        if (issue) begin
          left_r <= left_r - 1'b1;
          idx_r  <= idx_r + 1'b1;
          addr_r <= addr_inc;
        end
      end
      ST_FAIL: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_meta_r.chan0_out     <= '0;
      pend_meta_r.chan1_out     <= '0;
      pend_meta_r.total_written <= count_r;
      if (state_r == ST_EMIT) begin
        pend_mem_r                <= 1'b1;
        pend_meta_r.status        <= wcrb_pkg::STATUS_FRAME;
        pend_meta_r.frame_index   <= idx_r;
        pend_meta_r.last          <= (left_r == KW'(1));
      end else begin
        pend_mem_r                <= 1'b0;
        pend_meta_r.status        <= wcrb_pkg::STATUS_EMPTY;
        pend_meta_r.frame_index   <= end_r;
        pend_meta_r.last          <= 1'b1;
      end
    end
  end

  always_comb begin
    push_item = pend_meta_r;
    if (pend_mem_r) begin
      push_item.chan0_out = rd_lane[0];
      push_item.chan1_out = rd_lane[1];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      ofifo_r[owr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r <= 1'b0;
      ord_r <= 1'b0;
      occ_r <= '0;
    end else begin
      if (pend_r) begin
        owr_r <= ~owr_r;
      end
      if (pop) begin
        ord_r <= ~ord_r;
      end
      if (pend_r && !pop) begin
        occ_r <= occ_r + 1'b1;
      end else if (pop && !pend_r) begin
        occ_r <= occ_r - 1'b1;
      end
    end
  end

  assign out_valid = (occ_r != '0);
  assign out_data  = ofifo_r[ord_r];

endmodule

[hw/rtl/windowed_capture_ring_buffer_core.sv]
`timescale 1ns / 1ps

// Multichannel capture ring. Commands enter through a four-entry queue and
// are carried out one at a time by the back engine, which owns the sample
// memory, the write position and the 48-bit saturating frame count. A push
// or a clear is done in the idle state. A read plans in order (oldest-frame
// compute, end clamp, start clamp, ring address), then takes one cycle per
// frame emitted while the two-entry output buffer has room, via the single
// memory read port with its registered read; an empty window gives one
// result with status set. Input is taken whenever the queue has room. A
// channel-count or capacity write empties the ring, with no clearing pass.
module windowed_capture_ring_buffer_core #(
  parameter int DEPTH    = 64,
  parameter int CHANNELS = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wcrb_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wcrb_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [wcrb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wcrb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           f_valid;
  logic           f_ready;
  wcrb_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  wcrb_pkg::cmd_t q_cmd;
  wcrb_pkg::ctl_t ctl;

  wcrb_front #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .ctl       (ctl)
  );

  wcrb_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  wcrb_back #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/wcrb_checker.sv]
`timescale 1ns / 1ps

module wcrb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input wcrb_pkg::out_item_t              out_data
);

  logic                         mid_r;
  logic [wcrb_pkg::COUNT_W-1:0] prev_index_r;
  logic [wcrb_pkg::COUNT_W-1:0] prev_total_r;
  logic                         xfer;

  assign xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (xfer) begin
      mid_r        <= !out_data.last;
      prev_index_r <= out_data.frame_index;
      prev_total_r <= out_data.total_written;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && mid_r |-> out_data.status == wcrb_pkg::STATUS_FRAME &&
                      out_data.frame_index == prev_index_r + 1'b1 &&
                      out_data.total_written == prev_total_r)
    else $error("window frames out of sequence");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == wcrb_pkg::STATUS_EMPTY |->
      out_data.last && out_data.chan0_out == '0 && out_data.chan1_out == '0 &&
      !mid_r)
    else $error("malformed empty-window result");

  a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == wcrb_pkg::STATUS_FRAME |->
      out_data.frame_index < out_data.total_written)
    else $error("frame index beyond frames written");

endmodule

bind windowed_capture_ring_buffer_core wcrb_checker u_wcrb_checker (.*);
